>>> hdl/asmes_pkg.sv
`timescale 1ns / 1ps
package asmes_pkg;

	localparam int SAMPLE_W     = 12;
	localparam int GAIN_W       = 16;
	localparam int DIV_W        = 24;
	localparam int VOLT_W       = 24;
	localparam int ACC_W        = 28;
	localparam int FRAC_W       = 16;
	localparam int ADDR_W       = 4;
	localparam int DATA_W       = 32;
	localparam int REG_IDX_W    = 2;

	localparam int MUL_A_W      = 29;
	localparam int MUL_B_W      = 24;
	localparam int PROD_W       = MUL_A_W + MUL_B_W;
	localparam int V_W          = 29;
	localparam int SCALE_P_W    = SAMPLE_W + DIV_W;
	localparam int CORR_P_W     = V_W + GAIN_W;
	localparam int ROUND_SHIFT  = 8;
	localparam int CORR_W       = CORR_P_W - FRAC_W + 1;

	localparam int MEDIAN_DEPTH = 8;
	localparam int SLOT_W       = (MEDIAN_DEPTH > 1) ? $clog2(MEDIAN_DEPTH) : 1;
	localparam int MEDIAN_MID   = MEDIAN_DEPTH / 2;

	localparam logic [GAIN_W:0]     EMA_ONE      = (GAIN_W+1)'(65536);
	localparam logic [V_W-1:0]      VOLT_LIMIT   = V_W'(327680);
	localparam logic [GAIN_W-1:0]   CORR_SCALE   = GAIN_W'(64225);
	localparam logic [CORR_W-1:0]   CORR_OFFSET  = CORR_W'(6554);
	localparam logic [VOLT_W-1:0]   VOLT_MAX     = VOLT_W'(16777215);
	localparam logic [SCALE_P_W:0]  ROUND_HALF   = (SCALE_P_W+1)'(128);
	localparam logic [CORR_P_W:0]   CORR_HALF    = (CORR_P_W+1)'(32768);

	localparam logic [GAIN_W-1:0]   EMA_GAIN_RST = GAIN_W'(6554);
	localparam logic [DIV_W-1:0]    DIV_GAIN_RST = DIV_W'(184549);
	localparam logic [SAMPLE_W-1:0] DEAD_ZONE_RST = SAMPLE_W'(143);

	typedef struct packed {
		logic                filter_mode;
		logic [GAIN_W-1:0]   ema_gain;
		logic [DIV_W-1:0]    divider_gain;
		logic [SAMPLE_W-1:0] dead_zone_mv;
	} asmes_cfg_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_FILTER_MODE  = 2'd0,
		REG_EMA_GAIN     = 2'd1,
		REG_DIVIDER_GAIN = 2'd2,
		REG_DEAD_ZONE    = 2'd3
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MED,
		ST_EMA_A,
		ST_EMA_B,
		ST_EMA_SUM,
		ST_SCALE,
		ST_ROUND,
		ST_CORR,
		ST_FIN
	} seq_st_t;

	typedef enum logic [1:0] {
		MED_IDLE,
		MED_UP,
		MED_DN,
		MED_DONE
	} med_st_t;

endpackage

>>> hdl/asmes_regs.sv
`timescale 1ns / 1ps
module asmes_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [asmes_pkg::ADDR_W-1:0]     paddr,
	input  logic [asmes_pkg::DATA_W-1:0]     pwdata,
	output logic [asmes_pkg::DATA_W-1:0]     prdata,
	output logic                             pready,
	output asmes_pkg::asmes_cfg_t            cfg
);
	import asmes_pkg::*;

	asmes_cfg_t cfg_q;
	reg_idx_t   reg_idx;
	logic       wr_en;

	assign reg_idx = reg_idx_t'(paddr[REG_IDX_W+1:2]);
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.filter_mode  <= 1'b0;
			cfg_q.ema_gain     <= EMA_GAIN_RST;
			cfg_q.divider_gain <= DIV_GAIN_RST;
			cfg_q.dead_zone_mv <= DEAD_ZONE_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_FILTER_MODE:  cfg_q.filter_mode  <= pwdata[0];
				REG_EMA_GAIN:     cfg_q.ema_gain     <= pwdata[GAIN_W-1:0];
				REG_DIVIDER_GAIN: cfg_q.divider_gain <= pwdata[DIV_W-1:0];
				REG_DEAD_ZONE:    cfg_q.dead_zone_mv <= pwdata[SAMPLE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			REG_FILTER_MODE:  prdata = DATA_W'(cfg_q.filter_mode);
			REG_EMA_GAIN:     prdata = DATA_W'(cfg_q.ema_gain);
			REG_DIVIDER_GAIN: prdata = DATA_W'(cfg_q.divider_gain);
			REG_DEAD_ZONE:    prdata = DATA_W'(cfg_q.dead_zone_mv);
			default:          prdata = '0;
		endcase
	end

endmodule

>>> hdl/asmes_mul.sv
`timescale 1ns / 1ps
module asmes_mul (
	input  logic                          clk,
	input  logic                          en,
	input  logic [asmes_pkg::MUL_A_W-1:0] a,
	input  logic [asmes_pkg::MUL_B_W-1:0] b,
	output logic [asmes_pkg::PROD_W-1:0]  prod
);
	import asmes_pkg::*;

	logic [PROD_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= PROD_W'(a) * PROD_W'(b);
		end
	end

	assign prod = prod_q;

endmodule

>>> hdl/asmes_median.sv
`timescale 1ns / 1ps
module asmes_median (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [asmes_pkg::SAMPLE_W-1:0] sample,
	output logic                           done,
	output logic [asmes_pkg::SAMPLE_W-1:0] median
);
	import asmes_pkg::*;

	localparam logic [SLOT_W-1:0] LAST = SLOT_W'(MEDIAN_DEPTH - 1);

	med_st_t             state_q, state_nxt;
	logic [SAMPLE_W-1:0] win_q [MEDIAN_DEPTH];
	logic [SLOT_W-1:0]   slot_q;
	logic [SLOT_W-1:0]   idx_q;
	logic [SAMPLE_W-1:0] carry_q;
	logic                first_q;

	logic [SLOT_W-1:0]   rd_idx;
	logic [SLOT_W-1:0]   idx_step;
	logic [SAMPLE_W-1:0] rd_val;
	logic                at_end;
	logic                swap;

	always_comb begin
		if (state_q == MED_UP) begin
			at_end   = (idx_q == LAST);
			idx_step = idx_q + SLOT_W'(1);
		end else begin
			at_end   = (idx_q == '0);
			idx_step = idx_q - SLOT_W'(1);
		end
		rd_idx = at_end ? idx_q : idx_step;
		rd_val = win_q[rd_idx];
		swap   = (state_q == MED_UP) ? (carry_q > rd_val) : (rd_val > carry_q);
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			MED_IDLE: if (start) state_nxt = MED_UP;
			MED_UP: begin
				if (at_end) begin
					state_nxt = first_q ? MED_DN : MED_DONE;
				end else if (!swap && first_q) begin
					state_nxt = MED_DN;
				end
			end
			MED_DN: begin
				if (at_end) begin
					state_nxt = MED_DONE;
				end else if (!swap && first_q) begin
					state_nxt = MED_DONE;
				end
			end
			MED_DONE: state_nxt = MED_IDLE;
			default:  state_nxt = MED_IDLE;
		endcase
	end

	always_comb begin
		done   = (state_q == MED_DONE);
		median = win_q[MEDIAN_MID];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= MED_IDLE;
			slot_q  <= '0;
			idx_q   <= '0;
			carry_q <= '0;
			first_q <= 1'b0;
			for (int i = 0; i < MEDIAN_DEPTH; i++) begin
				win_q[i] <= '0;
			end
		end else begin
			state_q <= state_nxt;
			unique case (state_q)
				MED_IDLE: begin
					if (start) begin
						idx_q   <= slot_q;
						carry_q <= sample;
						first_q <= 1'b1;
					end
				end
				MED_UP: begin
					if (at_end) begin
						if (!first_q) win_q[idx_q] <= carry_q;
					end else if (swap) begin
						win_q[idx_q] <= rd_val;
						idx_q        <= idx_step;
						first_q      <= 1'b0;
					end else if (!first_q) begin
						win_q[idx_q] <= carry_q;
						carry_q      <= rd_val;
						idx_q        <= idx_step;
					end
				end
				MED_DN: begin
					if (at_end) begin
						win_q[idx_q] <= carry_q;
					end else if (swap) begin
						win_q[idx_q] <= rd_val;
						idx_q        <= idx_step;
						first_q      <= 1'b0;
					end else begin
						win_q[idx_q] <= carry_q;
						if (!first_q) begin
							carry_q <= rd_val;
							idx_q   <= idx_step;
						end
					end
				end
				MED_DONE: slot_q <= (slot_q == LAST) ? '0 : slot_q + SLOT_W'(1);
				default: ;
			endcase
		end
	end

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> (state_q == MED_IDLE))
		else $error("median pass started while busy");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != MED_IDLE) |-> (idx_q <= LAST))
		else $error("median index out of window");

	a_slot_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != MED_DONE) |=> $stable(slot_q))
		else $error("window slot moved outside pass end");

endmodule

>>> hdl/adc_sample_median_ema_scaler_unit.sv
`timescale 1ns / 1ps
// Filters one 12-bit millivolt sample per input beat and returns one result beat holding the
// filtered millivolt value and the scaled, corrected voltage in unsigned Q8.16. Samples below
// dead_zone_mv are taken as zero. In median mode the sample overwrites the next slot of an
// eight-entry window and one bubble pass walks it into place, one slot per cycle. In moving
// average mode the sample is blended into a running average weighted by ema_gain. All products
// go through one registered 29x24 multiplier, used by the sequencer in its blend, scale and
// correction steps. The block takes a new sample only when the sequencer is idle, which it
// re-enters as the result is registered; a finished result may wait in the output register
// while the next sample is accepted.
module adc_sample_median_ema_scaler_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [asmes_pkg::SAMPLE_W-1:0] sample_mv,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [asmes_pkg::SAMPLE_W-1:0] filtered_mv,
	output logic [asmes_pkg::VOLT_W-1:0]   volts_q16,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [asmes_pkg::ADDR_W-1:0]   paddr,
	input  logic [asmes_pkg::DATA_W-1:0]   pwdata,
	output logic [asmes_pkg::DATA_W-1:0]   prdata,
	output logic                           pready
);
	import asmes_pkg::*;

	asmes_cfg_t cfg;

	seq_st_t             state_q, state_nxt;
	logic [ACC_W-1:0]    acc_q;
	logic [SAMPLE_W-1:0] samp_q;
	logic [ACC_W-1:0]    tmp_q;
	logic [SAMPLE_W-1:0] filt_q;
	logic [V_W-1:0]      v_q;
	logic                out_valid_q;
	logic [SAMPLE_W-1:0] filtered_mv_q;
	logic [VOLT_W-1:0]   volts_q;

	logic [SAMPLE_W-1:0] samp_dz;
	logic                accept;
	logic                med_start;
	logic                med_done;
	logic [SAMPLE_W-1:0] med_val;
	logic                mul_en;
	logic [MUL_A_W-1:0]  mul_a;
	logic [MUL_B_W-1:0]  mul_b;
	logic [PROD_W-1:0]   prod;
	logic [GAIN_W:0]     gain_inv;
	logic [ACC_W:0]      ema_sum;
	logic [SCALE_P_W:0]  round_sum;
	logic [CORR_P_W:0]   corr_sum;
	logic [CORR_W-1:0]   corr_v;
	logic [CORR_W-1:0]   volt_sel;
	logic [VOLT_W-1:0]   volt_sat;
	logic                out_free;

	asmes_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	asmes_median u_median (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (med_start),
		.sample (samp_dz),
		.done   (med_done),
		.median (med_val)
	);

	asmes_mul u_mul (
		.clk  (clk),
		.en   (mul_en),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	always_comb begin
		samp_dz   = (sample_mv < cfg.dead_zone_mv) ? '0 : sample_mv;
		gain_inv  = EMA_ONE - {1'b0, cfg.ema_gain};
		ema_sum   = {1'b0, tmp_q} + {1'b0, prod[ACC_W-1:0]};
		round_sum = {1'b0, prod[SCALE_P_W-1:0]} + ROUND_HALF;
		corr_sum  = {1'b0, prod[CORR_P_W-1:0]} + CORR_HALF;
		corr_v    = corr_sum[CORR_P_W:FRAC_W] + CORR_OFFSET;
		volt_sel  = (v_q > VOLT_LIMIT) ? corr_v : CORR_W'(v_q);
		volt_sat  = (volt_sel > CORR_W'(VOLT_MAX)) ? VOLT_MAX : volt_sel[VOLT_W-1:0];
		out_free  = !out_valid_q || out_ready;
		accept    = in_valid && in_ready;
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE:    if (in_valid) state_nxt = cfg.filter_mode ? ST_EMA_A : ST_MED;
			ST_MED:     if (med_done) state_nxt = ST_SCALE;
			ST_EMA_A:   state_nxt = ST_EMA_B;
			ST_EMA_B:   state_nxt = ST_EMA_SUM;
			ST_EMA_SUM: state_nxt = ST_SCALE;
			ST_SCALE:   state_nxt = ST_ROUND;
			ST_ROUND:   state_nxt = ST_CORR;
			ST_CORR:    state_nxt = ST_FIN;
			ST_FIN:     if (out_free) state_nxt = ST_IDLE;
			default:    state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		med_start = 1'b0;
		mul_en    = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready  = 1'b1;
				med_start = in_valid && !cfg.filter_mode;
			end
			ST_EMA_A: begin
				mul_en = 1'b1;
				mul_a  = MUL_A_W'(acc_q);
				mul_b  = MUL_B_W'(gain_inv);
			end
			ST_EMA_B: begin
				mul_en = 1'b1;
				mul_a  = MUL_A_W'(samp_q);
				mul_b  = MUL_B_W'(cfg.ema_gain);
			end
			ST_SCALE: begin
				mul_en = 1'b1;
				mul_a  = MUL_A_W'(filt_q);
				mul_b  = cfg.divider_gain;
			end
			ST_CORR: begin
				mul_en = 1'b1;
				mul_a  = v_q;
				mul_b  = MUL_B_W'(CORR_SCALE);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			acc_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_EMA_SUM) begin
				acc_q <= ema_sum[ACC_W-1:0];
			end
			if (state_q == ST_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			samp_q <= samp_dz;
		end
		if (state_q == ST_EMA_B) begin
			tmp_q <= prod[ACC_W+FRAC_W-1:FRAC_W];
		end
		if (state_q == ST_EMA_SUM) begin
			filt_q <= ema_sum[ACC_W-1:FRAC_W];
		end else if (state_q == ST_MED && med_done) begin
			filt_q <= med_val;
		end
		if (state_q == ST_ROUND) begin
			v_q <= round_sum[SCALE_P_W:ROUND_SHIFT];
		end
		if (state_q == ST_FIN && out_free) begin
			filtered_mv_q <= filt_q;
			volts_q       <= volt_sat;
		end
	end

	assign out_valid   = out_valid_q;
	assign filtered_mv = filtered_mv_q;
	assign volts_q16   = volts_q;

	a_med_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		med_done |-> (state_q == ST_MED))
		else $error("median result outside median wait");

	a_med_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !cfg.filter_mode) |=> (state_q == ST_MED))
		else $error("median beat did not start the window pass");

	a_acc_untouched: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MED) |=> $stable(acc_q))
		else $error("average accumulator changed in median mode");

endmodule

>>> tb/adc_sample_median_ema_scaler_checker.sv
`timescale 1ns / 1ps
module adc_sample_median_ema_scaler_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           in_ready,
	input  logic [asmes_pkg::SAMPLE_W-1:0] sample_mv,
	input  logic                           out_valid,
	input  logic                           out_ready,
	input  logic [asmes_pkg::SAMPLE_W-1:0] filtered_mv,
	input  logic [asmes_pkg::VOLT_W-1:0]   volts_q16,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [asmes_pkg::ADDR_W-1:0]   paddr,
	input  logic [asmes_pkg::DATA_W-1:0]   pwdata,
	input  logic                           pready,
	output int                             mismatch_count,
	output int                             results_owed
);
	import asmes_pkg::*;

	localparam longint unsigned VOLT_KNEE   = 327680;
	localparam longint unsigned TRIM_SCALE  = 64225;
	localparam longint unsigned TRIM_OFFSET = 6554;
	localparam longint unsigned VOLT_CEIL   = 16777215;

	typedef struct packed {
		logic [SAMPLE_W-1:0] mv;
		logic [VOLT_W-1:0]   volts;
	} reading_t;

	logic                filter_mode;
	logic [GAIN_W-1:0]   ema_gain;
	logic [DIV_W-1:0]    divider_gain;
	logic [SAMPLE_W-1:0] dead_zone_mv;

	logic [ACC_W-1:0]    average_acc;
	logic [SAMPLE_W-1:0] window [MEDIAN_DEPTH];
	int                  next_slot;

	reading_t            owed_q [$];
	reading_t            oldest;

	function automatic logic [SAMPLE_W-1:0] median_insert(logic [SAMPLE_W-1:0] s);
		int                  c;
		int                  i;
		logic [SAMPLE_W-1:0] t;
		c = next_slot;
		window[c] = s;
		if (c < MEDIAN_DEPTH - 1 && window[c] > window[c + 1]) begin
			for (i = c; i < MEDIAN_DEPTH - 1; i++) begin
				if (window[i] > window[i + 1]) begin
					t = window[i];
					window[i] = window[i + 1];
					window[i + 1] = t;
				end
			end
		end else if (c > 0 && window[c - 1] > window[c]) begin
			for (i = c; i > 0; i--) begin
				if (window[i] < window[i - 1]) begin
					t = window[i];
					window[i] = window[i - 1];
					window[i - 1] = t;
				end
			end
		end
		next_slot = (c + 1) % MEDIAN_DEPTH;
		return window[MEDIAN_DEPTH / 2];
	endfunction

	function automatic logic [SAMPLE_W-1:0] average_update(logic [SAMPLE_W-1:0] s);
		longint unsigned k;
		longint unsigned blend;
		k = ema_gain;
		blend = longint'(average_acc) * (64'd65536 - k) + (longint'(s) << 16) * k;
		average_acc = ACC_W'(blend >> 16);
		return average_acc[ACC_W-1:FRAC_W];
	endfunction

	function automatic logic [VOLT_W-1:0] scale_to_volts(logic [SAMPLE_W-1:0] f);
		longint unsigned v;
		v = (longint'(f) * longint'(divider_gain) + 128) >> 8;
		if (v > VOLT_KNEE)
			v = ((v * TRIM_SCALE + 32768) >> 16) + TRIM_OFFSET;
		if (v > VOLT_CEIL)
			v = VOLT_CEIL;
		return VOLT_W'(v);
	endfunction

	function automatic reading_t filter_sample(logic [SAMPLE_W-1:0] raw);
		logic [SAMPLE_W-1:0] s;
		reading_t            r;
		s = (raw < dead_zone_mv) ? '0 : raw;
		r.mv = filter_mode ? average_update(s) : median_insert(s);
		r.volts = scale_to_volts(r.mv);
		return r;
	endfunction

	task automatic report_mismatch(string what, longint want, longint got);
		$display("%0t: %s: expected %0d, got %0d", $realtime, what, want, got);
		mismatch_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_mode = 1'b0;
			ema_gain = EMA_GAIN_RST;
			divider_gain = DIV_GAIN_RST;
			dead_zone_mv = DEAD_ZONE_RST;
			average_acc = '0;
			for (int i = 0; i < MEDIAN_DEPTH; i++)
				window[i] = '0;
			next_slot = 0;
			owed_q.delete();
			mismatch_count = 0;
			results_owed = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[3:2]))
					REG_FILTER_MODE: begin
						filter_mode = pwdata[0];
					end
					REG_EMA_GAIN: begin
						ema_gain = pwdata[GAIN_W-1:0];
					end
					REG_DIVIDER_GAIN: begin
						divider_gain = pwdata[DIV_W-1:0];
					end
					REG_DEAD_ZONE: begin
						dead_zone_mv = pwdata[SAMPLE_W-1:0];
					end
					default: begin
					end
				endcase
			end
			if (out_valid && out_ready) begin
				if (owed_q.size() == 0) begin
					report_mismatch("result beat with none outstanding, filtered_mv",
						-1, filtered_mv);
				end else begin
					oldest = owed_q.pop_front();
					if (filtered_mv !== oldest.mv)
						report_mismatch("filtered_mv", oldest.mv, filtered_mv);
					if (volts_q16 !== oldest.volts)
						report_mismatch("volts_q16", oldest.volts, volts_q16);
				end
			end
			if (in_valid && in_ready)
				owed_q.push_back(filter_sample(sample_mv));
			results_owed = owed_q.size();
		end
	end

endmodule

>>> tb/adc_sample_median_ema_scaler_unit_test.sv
`timescale 1ns / 1ps
module adc_sample_median_ema_scaler_unit_test;
	import asmes_pkg::*;

	localparam int RANDOM_ITEMS = 1850;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic [SAMPLE_W-1:0] sample_mv;
	logic                out_valid;
	logic                out_ready;
	logic [SAMPLE_W-1:0] filtered_mv;
	logic [VOLT_W-1:0]   volts_q16;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [DATA_W-1:0]   pwdata;
	logic [DATA_W-1:0]   prdata;
	logic                pready;

	int mismatch_count;
	int results_owed;
	int items_sent;
	bit steady;
	int level_mv;
	int zone_mv;

	adc_sample_median_ema_scaler_unit DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.sample_mv   (sample_mv),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.filtered_mv (filtered_mv),
		.volts_q16   (volts_q16),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	adc_sample_median_ema_scaler_checker filter_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.sample_mv      (sample_mv),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.filtered_mv    (filtered_mv),
		.volts_q16      (volts_q16),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.pready         (pready),
		.mismatch_count (mismatch_count),
		.results_owed   (results_owed)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#15_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	function automatic int next_gap();
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [SAMPLE_W-1:0] next_sample();
		int r;
		int v;
		r = $urandom_range(0, 99);
		if (r < 50)
			v = $urandom_range(0, 4095);
		else if (r < 65)
			v = zone_mv + int'($urandom_range(0, 4)) - 2;
		else if (r < 75)
			v = $urandom_range(0, 1) ? 4095 : 0;
		else
			v = level_mv + int'($urandom_range(0, 64)) - 32;
		if (v < 0)
			v = 0;
		if (v > 4095)
			v = 4095;
		return v[SAMPLE_W-1:0];
	endfunction

	task automatic send_sample(input logic [SAMPLE_W-1:0] s);
		int gap;
		gap = next_gap();
		@(negedge clk);
		in_valid <= 1'b1;
		sample_mv <= s;
		do
			@(posedge clk);
		while (!(in_valid && in_ready));
		items_sent++;
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (results_owed != 0)
			@(negedge clk);
	endtask

	task automatic reg_write(input reg_idx_t idx, input logic [DATA_W-1:0] value,
		input logic [DATA_W-1:0] mask);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= ($urandom & ~mask) | (value & mask);
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic configure(input logic mode, input int gain, input int div, input int dz);
		reg_write(REG_FILTER_MODE, DATA_W'(mode), 32'h1);
		reg_write(REG_EMA_GAIN, gain, 32'hFFFF);
		reg_write(REG_DIVIDER_GAIN, div, 32'hFF_FFFF);
		reg_write(REG_DEAD_ZONE, dz, 32'hFFF);
		zone_mv = dz;
	endtask

	task automatic configure_random();
		int gain;
		int div;
		int dz;
		case ($urandom_range(0, 4))
			0: gain = 0;
			1: gain = 65535;
			2: gain = $urandom_range(1, 64);
			default: gain = $urandom_range(0, 65535);
		endcase
		case ($urandom_range(0, 5))
			0: div = 0;
			1: div = 24'hFF_FFFF;
			2: div = 184549;
			3: div = $urandom_range(0, 24'hFF_FFFF);
			default: div = $urandom_range(0, 400000);
		endcase
		case ($urandom_range(0, 4))
			0: dz = 0;
			1: dz = 4095;
			default: dz = $urandom_range(0, 600);
		endcase
		configure(1'($urandom_range(0, 1)), gain, div, dz);
	endtask

	initial begin
		int len;
		bit level;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if ($urandom_range(0, 9) == 0) begin
				level = 1'b1;
				len = $urandom_range(50, 200);
			end else begin
				level = 1'($urandom_range(0, 1));
				if (level)
					len = $urandom_range(1, 6);
				else if ($urandom_range(0, 9) == 0)
					len = $urandom_range(15, 50);
				else
					len = $urandom_range(1, 3);
			end
			@(negedge clk);
			out_ready <= level;
			repeat (len - 1) @(negedge clk);
		end
	end

	initial begin
		static logic [SAMPLE_W-1:0] opening [10] = '{0, 142, 143, 144, 4095, 4095, 4095, 4095,
			4095, 2048};
		int random_goal;
		arst_n = 1'b0;
		in_valid = 1'b0;
		sample_mv = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		items_sent = 0;
		steady = 1'b0;
		level_mv = 0;
		zone_mv = 143;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset settings: median window with the default dead zone.
		foreach (opening[i])
			send_sample(opening[i]);
		drain();
		configure(1'b1, 65535, 24'hFF_FFFF, 0);
		send_sample(4095);
		send_sample(0);
		send_sample(1);
		drain();
		configure(1'b1, 0, 184549, 4095);
		send_sample(4095);
		send_sample(4094);
		drain();
		configure(1'b0, 6554, 0, 0);
		send_sample(4095);
		send_sample(0);
		drain();
		configure(1'b1, 1, 1, 2048);
		send_sample(2047);
		send_sample(4095);

		random_goal = items_sent + RANDOM_ITEMS;
		while (items_sent < random_goal) begin
			drain();
			configure_random();
			steady = ($urandom_range(0, 3) == 0);
			level_mv = $urandom_range(0, 4095);
			repeat ($urandom_range(60, 200)) begin
				if ($urandom_range(0, 49) == 0)
					level_mv = $urandom_range(0, 4095);
				send_sample(next_sample());
			end
		end

		drain();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

>>> filelist.f
hdl/asmes_pkg.sv
hdl/asmes_regs.sv
hdl/asmes_mul.sv
hdl/asmes_median.sv
hdl/adc_sample_median_ema_scaler_unit.sv
tb/adc_sample_median_ema_scaler_checker.sv
tb/adc_sample_median_ema_scaler_unit_test.sv
